### sv/rcc_pkg.sv
// Package for the calendar clock: time word type, opcodes, calendar tables
// and the small date helpers shared by the update and conversion stages.
// No dependencies.
`default_nettype none

package rcc_pkg;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } time_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [11:0] RST_YEAR  = 12'd2017;
  localparam logic [3:0]  RST_MONTH = 4'd12;
  localparam logic [4:0]  RST_DAY   = 5'd1;

  localparam int FLAG_SEC   = 0;
  localparam int FLAG_10S   = 1;
  localparam int FLAG_MIN   = 2;
  localparam int FLAG_5MIN  = 3;
  localparam int FLAG_10MIN = 4;
  localparam int FLAG_HOUR  = 5;
  localparam int FLAG_2H    = 6;
  localparam int FLAG_DAY   = 7;

  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
  localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
  localparam logic [31:0] SEC_PER_MIN  = 32'd60;

  // 64*k mod 100 and 64*k mod 400 for k = 0..24 (period 25 since 1600 = 4*400)
  localparam logic [6:0] MOD100_TAB [25] = '{
    7'd0,  7'd64, 7'd28, 7'd92, 7'd56, 7'd20, 7'd84, 7'd48, 7'd12, 7'd76,
    7'd40, 7'd4,  7'd68, 7'd32, 7'd96, 7'd60, 7'd24, 7'd88, 7'd52, 7'd16,
    7'd80, 7'd44, 7'd8,  7'd72, 7'd36};
  localparam logic [8:0] MOD400_TAB [25] = '{
    9'd0,   9'd64,  9'd128, 9'd192, 9'd256, 9'd320, 9'd384, 9'd48,  9'd112,
    9'd176, 9'd240, 9'd304, 9'd368, 9'd32,  9'd96,  9'd160, 9'd224, 9'd288,
    9'd352, 9'd16,  9'd80,  9'd144, 9'd208, 9'd272, 9'd336};

  function automatic logic [4:0] fold25(input logic [5:0] hi);
    logic [5:0] r;
    r = hi;
    if (r >= 6'd50) begin
      r = r - 6'd50;
    end else if (r >= 6'd25) begin
      r = r - 6'd25;
    end
    return r[4:0];
  endfunction

  function automatic logic [6:0] year_mod100(input logic [11:0] y);
    logic [7:0] s;
    s = {1'b0, MOD100_TAB[fold25(y[11:6])]} + {2'b00, y[5:0]};
    if (s >= 8'd100) begin
      s = s - 8'd100;
    end
    return s[6:0];
  endfunction

  function automatic logic [8:0] year_mod400(input logic [11:0] y);
    logic [9:0] s;
    s = {1'b0, MOD400_TAB[fold25(y[11:6])]} + {4'b0000, y[5:0]};
    if (s >= 10'd400) begin
      s = s - 10'd400;
    end
    return s[8:0];
  endfunction

  function automatic logic gregorian_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && ((year_mod100(y) != 7'd0) || (year_mod400(y) == 9'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    unique case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    if (leap && (m > 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  function automatic logic [15:0] days_before_year(input logic [6:0] y);
    logic [6:0] ym1;
    ym1 = y - 7'd1;
    if (y == 7'd0) begin
      return 16'd0;
    end
    return 16'(16'd365 * {9'd0, y}) + {11'd0, ym1[6:2]} + 16'd1;
  endfunction

  function automatic logic mult_of5(input logic [5:0] v);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 13; i++) begin
      if (v == 6'(5 * i)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic mult_of10(input logic [5:0] v);
    return mult_of5(v) && !v[0];
  endfunction

endpackage

`default_nettype wire

### sv/rcc_update.sv
// Calendar state registers with the tick carry chain and the set load.
// Produces the time after the word and the change flags. Uses rcc_pkg.
`default_nettype none

module rcc_update (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          opcode,
  input  wire rcc_pkg::time_t set_time,
  output rcc_pkg::time_t     new_time,
  output logic [7:0]         flags
);
  import rcc_pkg::*;

  time_t      cur_r;
  time_t      tick_time;
  logic [6:0] s1;
  logic [6:0] mi1;
  logic [5:0] h1;
  logic [5:0] d1;
  logic [4:0] m1;
  logic [4:0] len;

  always_comb begin
    tick_time = cur_r;
    s1  = {1'b0, cur_r.second} + 7'd1;
    mi1 = {1'b0, cur_r.minute} + 7'd1;
    h1  = {1'b0, cur_r.hour} + 6'd1;
    d1  = {1'b0, cur_r.day} + 6'd1;
    m1  = {1'b0, cur_r.month} + 5'd1;
    len = month_len(cur_r.month, gregorian_leap(cur_r.year));
    if (s1 < 7'd60) begin
      tick_time.second = s1[5:0];
    end else begin
      tick_time.second = 6'(s1 - 7'd60);
      if (mi1 < 7'd60) begin
        tick_time.minute = mi1[5:0];
      end else begin
        tick_time.minute = 6'(mi1 - 7'd60);
        if (h1 < 6'd24) begin
          tick_time.hour = h1[4:0];
        end else begin
          tick_time.hour = 5'(h1 - 6'd24);
          if (d1 <= {1'b0, len}) begin
            tick_time.day = d1[4:0];
          end else begin
            tick_time.day = 5'(d1 - {1'b0, len});
            if (m1 > 5'd12) begin
              tick_time.month = 4'(m1 - 5'd12);
              tick_time.year  = cur_r.year + 12'd1;
            end else begin
              tick_time.month = m1[3:0];
            end
          end
        end
      end
    end
  end

  assign new_time = (opcode == OP_SET) ? set_time : tick_time;

  always_comb begin
    flags = '0;
    if (new_time.second != cur_r.second) begin
      flags[FLAG_SEC] = 1'b1;
      flags[FLAG_10S] = mult_of10(new_time.second);
    end
    if (new_time.minute != cur_r.minute) begin
      flags[FLAG_MIN]   = 1'b1;
      flags[FLAG_5MIN]  = mult_of5(new_time.minute);
      flags[FLAG_10MIN] = mult_of10(new_time.minute);
    end
    if (new_time.hour != cur_r.hour) begin
      flags[FLAG_HOUR] = 1'b1;
      flags[FLAG_2H]   = !new_time.hour[0];
      flags[FLAG_DAY]  = (new_time.hour == 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '{year: RST_YEAR, month: RST_MONTH, day: RST_DAY,
                 hour: 5'd0, minute: 6'd0, second: 6'd0};
    end else if (adv) begin
      cur_r <= new_time;
    end
  end

endmodule

`default_nettype wire

### sv/rcc_days.sv
// Range check of a stored time and its day count since 2000-01-01,
// using year mod 100 and a leap year every fourth year. Uses rcc_pkg.
`default_nettype none

module rcc_days (
  input  wire rcc_pkg::time_t tm,
  output logic [15:0]         days,
  output logic                ok
);
  import rcc_pkg::*;

  logic [6:0] y100;
  logic       leap;

  assign y100 = year_mod100(tm.year);
  assign leap = (y100[1:0] == 2'b00);

  assign ok = (tm.month >= 4'd1) && (tm.month <= 4'd12) && (tm.day != 5'd0) &&
              (tm.day <= month_len(tm.month, leap)) && (tm.hour <= 5'd23) &&
              (tm.minute <= 6'd59) && (tm.second <= 6'd59);

  assign days = days_before_year(y100) + {7'd0, days_before_month(tm.month, leap)} +
                {11'd0, tm.day} - 16'd1;

endmodule

`default_nettype wire

### sv/rcc_secs.sv
// Scales a day count and time of day to seconds; zero for an invalid time.
// Uses rcc_pkg.
`default_nettype none

module rcc_secs (
  input  wire logic [15:0]    days,
  input  wire logic           ok,
  input  wire rcc_pkg::time_t tm,
  output logic [31:0]         secs
);
  import rcc_pkg::*;

  logic [31:0] total;

  assign total = {16'd0, days} * SEC_PER_DAY + {27'd0, tm.hour} * SEC_PER_HOUR +
                 {26'd0, tm.minute} * SEC_PER_MIN + {26'd0, tm.second};
  assign secs = ok ? total : 32'd0;

endmodule

`default_nettype wire

### sv/rtc_calendar_counter.sv
// Calendar clock top level: input register, state update, day count and
// seconds stages, output register. Uses rcc_pkg, rcc_update, rcc_days, rcc_secs.
//
// Takes one word per cycle (tick or set) while the output is not stalled and
// returns one result word per input word, after the input, update, day count
// and output registers. The calendar state advances as a word leaves the input
// register, so words may follow each other in consecutive cycles; the day count
// and the seconds product each have a register stage of their own. A stall on
// the output backs up through the four registers, after which in_stall rises.
`default_nettype none

module rtc_calendar_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [11:0] in_set_year,
  input  wire logic [3:0]  in_set_month,
  input  wire logic [4:0]  in_set_day,
  input  wire logic [4:0]  in_set_hour,
  input  wire logic [5:0]  in_set_minute,
  input  wire logic [5:0]  in_set_second,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_cur_year,
  output logic [3:0]       out_cur_month,
  output logic [4:0]       out_cur_day,
  output logic [4:0]       out_cur_hour,
  output logic [5:0]       out_cur_minute,
  output logic [5:0]       out_cur_second,
  output logic [31:0]      out_seconds_since_2000,
  output logic             out_time_valid,
  output logic [7:0]       out_event_flags
);
  import rcc_pkg::*;

  logic        i_valid_r;
  logic        i_op_r;
  time_t       i_set_r;
  logic        m_valid_r;
  time_t       m_time_r;
  logic [7:0]  m_flags_r;
  logic        c_valid_r;
  time_t       c_time_r;
  logic [7:0]  c_flags_r;
  logic [15:0] c_days_r;
  logic        c_ok_r;
  logic        out_valid_r;
  time_t       o_time_r;
  logic [7:0]  o_flags_r;
  logic [31:0] o_secs_r;
  logic        o_ok_r;

  logic        o_free;
  logic        c_free;
  logic        m_free;
  logic        i_free;
  logic        adv;
  time_t       upd_time;
  logic [7:0]  upd_flags;
  logic [15:0] days;
  logic        ok;
  logic [31:0] secs;

  assign o_free   = !out_valid_r || !out_stall;
  assign c_free   = !c_valid_r || o_free;
  assign m_free   = !m_valid_r || c_free;
  assign i_free   = !i_valid_r || m_free;
  assign in_stall = !i_free;
  assign adv      = i_valid_r && m_free;

  rcc_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .opcode   (i_op_r),
    .set_time (i_set_r),
    .new_time (upd_time),
    .flags    (upd_flags)
  );

  rcc_days u_days (
    .tm   (m_time_r),
    .days (days),
    .ok   (ok)
  );

  rcc_secs u_secs (
    .days (c_days_r),
    .ok   (c_ok_r),
    .tm   (c_time_r),
    .secs (secs)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (i_free) begin
        i_valid_r <= in_valid;
      end
      if (m_free) begin
        m_valid_r <= i_valid_r;
      end
      if (c_free) begin
        c_valid_r <= m_valid_r;
      end
      if (o_free) begin
        out_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && i_free) begin
      i_op_r  <= in_opcode;
      i_set_r <= '{year: in_set_year, month: in_set_month, day: in_set_day,
                   hour: in_set_hour, minute: in_set_minute, second: in_set_second};
    end
    if (adv) begin
      m_time_r  <= upd_time;
      m_flags_r <= upd_flags;
    end
    if (m_valid_r && c_free) begin
      c_time_r  <= m_time_r;
      c_flags_r <= m_flags_r;
      c_days_r  <= days;
      c_ok_r    <= ok;
    end
    if (c_valid_r && o_free) begin
      o_time_r  <= c_time_r;
      o_flags_r <= c_flags_r;
      o_secs_r  <= secs;
      o_ok_r    <= c_ok_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_cur_year           = o_time_r.year;
  assign out_cur_month          = o_time_r.month;
  assign out_cur_day            = o_time_r.day;
  assign out_cur_hour           = o_time_r.hour;
  assign out_cur_minute         = o_time_r.minute;
  assign out_cur_second         = o_time_r.second;
  assign out_seconds_since_2000 = o_secs_r;
  assign out_time_valid         = o_ok_r;
  assign out_event_flags        = o_flags_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_ok_r |-> o_secs_r == 32'd0)
    else $error("seconds count nonzero for invalid time");

  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_ok_r |-> o_time_r.month >= 4'd1 && o_time_r.month <= 4'd12 &&
      o_time_r.day != 5'd0 && o_time_r.hour <= 5'd23 && o_time_r.minute <= 6'd59 &&
      o_time_r.second <= 6'd59)
    else $error("time flagged valid while out of range");

  a_flag_nesting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_flags_r[FLAG_10S] || o_flags_r[FLAG_SEC]) &&
      (!o_flags_r[FLAG_5MIN] || o_flags_r[FLAG_MIN]) &&
      (!o_flags_r[FLAG_DAY] || o_flags_r[FLAG_2H]) &&
      (!o_flags_r[FLAG_2H] || o_flags_r[FLAG_HOUR]))
    else $error("event flags inconsistent");

  a_tick_moves_second: assert property (@(posedge clk) disable iff (!rst_n)
    adv && i_op_r == OP_TICK |=> m_valid_r && m_flags_r[FLAG_SEC])
    else $error("tick did not change the second");

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for rtc_calendar_counter: directed calendar corners, then
// random set/tick sequences, with a shadow clock that predicts every result word.
// Depends on rcc_pkg and the rtc_calendar_counter RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 500;

  typedef struct packed {
    time_t       now;
    logic [31:0] seconds;
    logic        valid;
    logic [7:0]  flags;
  } reading_t;

  class rtc_shadow;
    time_t    clock_now;
    reading_t expected_readings[$];
    int       errors;
    int       tick_words;
    int       set_words;
    int       valid_readings;
    int       midnights;

    function new();
      clock_now.year   = RST_YEAR;
      clock_now.month  = RST_MONTH;
      clock_now.day    = RST_DAY;
      clock_now.hour   = '0;
      clock_now.minute = '0;
      clock_now.second = '0;
    endfunction

    static function bit gregorian_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int unsigned month_days(int unsigned m, bit leap);
      case (m)
        2: begin
          return leap ? 29 : 28;
        end
        4, 6, 9, 11: begin
          return 30;
        end
        default: begin
          return 31;
        end
      endcase
    endfunction

    function void advance_one_second();
      int unsigned sec, mnt, hr, dy, mon, len;
      bit carry;
      sec = clock_now.second + 1;
      carry = sec >= 60;
      if (carry) sec -= 60;
      mnt = clock_now.minute;
      if (carry) begin
        mnt++;
        carry = mnt >= 60;
        if (carry) mnt -= 60;
      end
      hr = clock_now.hour;
      if (carry) begin
        hr++;
        carry = hr >= 24;
        if (carry) hr -= 24;
      end
      dy = clock_now.day;
      if (carry) begin
        len = month_days(clock_now.month, gregorian_leap(clock_now.year));
        dy++;
        carry = dy > len;
        if (carry) dy -= len;
      end
      mon = clock_now.month;
      if (carry) begin
        mon++;
        carry = mon > 12;
        if (carry) begin
          mon -= 12;
          clock_now.year = clock_now.year + 12'd1;
        end
      end
      clock_now.month  = 4'(mon);
      clock_now.day    = 5'(dy);
      clock_now.hour   = 5'(hr);
      clock_now.minute = 6'(mnt);
      clock_now.second = 6'(sec);
    endfunction

    // leap rule of the seconds count: two-digit year divisible by four
    function bit time_is_valid(time_t t);
      int unsigned y;
      y = t.year % 100;
      if (t.month < 1 || t.month > 12) return 1'b0;
      if (t.day == 0 || t.day > month_days(t.month, (y & 3) == 0)) return 1'b0;
      return (t.hour <= 23) && (t.minute <= 59) && (t.second <= 59);
    endfunction

    function int unsigned seconds_since_2000(time_t t);
      int unsigned y, total;
      bit leap;
      y = t.year % 100;
      leap = (y & 3) == 0;
      total = (y != 0) ? 365 * y + (y - 1) / 4 + 1 : 0;
      for (int m = 1; m < t.month && m <= 12; m++) total += month_days(m, leap);
      total += t.day - 1;
      total = total * 24 + t.hour;
      total = total * 60 + t.minute;
      return total * 60 + t.second;
    endfunction

    function void note_word(logic op, time_t payload);
      time_t    was;
      reading_t r;
      was = clock_now;
      if (op == OP_SET) begin
        clock_now = payload;
        set_words++;
      end else begin
        advance_one_second();
        tick_words++;
      end
      r.now = clock_now;
      r.valid = time_is_valid(clock_now);
      r.seconds = r.valid ? seconds_since_2000(clock_now) : 32'd0;
      r.flags = '0;
      if (clock_now.second != was.second) begin
        r.flags[FLAG_SEC] = 1'b1;
        r.flags[FLAG_10S] = clock_now.second % 10 == 0;
      end
      if (clock_now.minute != was.minute) begin
        r.flags[FLAG_MIN]   = 1'b1;
        r.flags[FLAG_5MIN]  = clock_now.minute % 5 == 0;
        r.flags[FLAG_10MIN] = clock_now.minute % 10 == 0;
      end
      if (clock_now.hour != was.hour) begin
        r.flags[FLAG_HOUR] = 1'b1;
        r.flags[FLAG_2H]   = !clock_now.hour[0];
        r.flags[FLAG_DAY]  = clock_now.hour == 0;
      end
      if (r.valid) valid_readings++;
      if (r.flags[FLAG_DAY]) midnights++;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: result word expected none, got %0d-%0d-%0d %0d:%0d:%0d", $time,
                 got.now.year, got.now.month, got.now.day, got.now.hour, got.now.minute,
                 got.now.second);
        return;
      end
      want = expected_readings.pop_front();
      compare_field("cur_year", want.now.year, got.now.year);
      compare_field("cur_month", want.now.month, got.now.month);
      compare_field("cur_day", want.now.day, got.now.day);
      compare_field("cur_hour", want.now.hour, got.now.hour);
      compare_field("cur_minute", want.now.minute, got.now.minute);
      compare_field("cur_second", want.now.second, got.now.second);
      compare_field("seconds_since_2000", want.seconds, got.seconds);
      compare_field("time_valid", want.valid, got.valid);
      compare_field("event_flags", want.flags, got.flags);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_TICK;
  logic [11:0] in_set_year = '0;
  logic [3:0]  in_set_month = '0;
  logic [4:0]  in_set_day = '0;
  logic [4:0]  in_set_hour = '0;
  logic [5:0]  in_set_minute = '0;
  logic [5:0]  in_set_second = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_cur_year;
  logic [3:0]  out_cur_month;
  logic [4:0]  out_cur_day;
  logic [4:0]  out_cur_hour;
  logic [5:0]  out_cur_minute;
  logic [5:0]  out_cur_second;
  logic [31:0] out_seconds_since_2000;
  logic        out_time_valid;
  logic [7:0]  out_event_flags;

  rtc_shadow shadow = new();
  int        idle_cycles = 0;
  int        words_sent = 0;
  bit        send_burst = 1'b0;
  bit        recv_burst = 1'b0;

  rtc_calendar_counter i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_opcode              (in_opcode),
    .in_set_year            (in_set_year),
    .in_set_month           (in_set_month),
    .in_set_day             (in_set_day),
    .in_set_hour            (in_set_hour),
    .in_set_minute          (in_set_minute),
    .in_set_second          (in_set_second),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_cur_year           (out_cur_year),
    .out_cur_month          (out_cur_month),
    .out_cur_day            (out_cur_day),
    .out_cur_hour           (out_cur_hour),
    .out_cur_minute         (out_cur_minute),
    .out_cur_second         (out_cur_second),
    .out_seconds_since_2000 (out_seconds_since_2000),
    .out_time_valid         (out_time_valid),
    .out_event_flags        (out_event_flags)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // note accepted words before checking results
  always @(posedge clk) begin
    time_t    payload;
    reading_t got;
    if (rst_n) begin
      payload = {in_set_year, in_set_month, in_set_day, in_set_hour, in_set_minute,
                 in_set_second};
      got = {out_cur_year, out_cur_month, out_cur_day, out_cur_hour, out_cur_minute,
             out_cur_second, out_seconds_since_2000, out_time_valid, out_event_flags};
      if (in_valid && !in_stall) shadow.note_word(in_opcode, payload);
      if (out_valid && !out_stall) shadow.check_reading(got);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("rtc_calendar_counter test failed");
    $finish;
  end

  initial begin
    int hold;
    wait (rst_n);
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
    end
  end

  function automatic time_t stamp(int y, int mo, int d, int h, int mi, int s);
    time_t t;
    t.year   = 12'(y);
    t.month  = 4'(mo);
    t.day    = 5'(d);
    t.hour   = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    return t;
  endfunction

  function automatic time_t any_time();
    return stamp($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  function automatic time_t valid_time();
    int y, mo;
    y = $urandom_range(0, 4095);
    mo = $urandom_range(1, 12);
    return stamp(y, mo, $urandom_range(1, rtc_shadow::month_days(mo,
                 rtc_shadow::gregorian_leap(y))), $urandom_range(0, 23),
                 $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // end of a month, often at a century, a few seconds before the carry
  function automatic time_t near_rollover();
    int y, mo, len;
    y = $urandom_range(0, 1) ? $urandom_range(0, 4095)
                             : $urandom_range(0, 40) * 100 + $urandom_range(0, 1) * 99;
    mo = $urandom_range(1, 12);
    len = rtc_shadow::month_days(mo, rtc_shadow::gregorian_leap(y % 4096));
    return stamp(y, mo, $urandom_range(len - 1, len),
                 $urandom_range(0, 2) != 0 ? 23 : $urandom_range(0, 23),
                 $urandom_range(0, 2) != 0 ? 59 : $urandom_range(0, 59),
                 $urandom_range(45, 59));
  endfunction

  task automatic send_word(input logic op, input time_t t);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_set_year   <= t.year;
    in_set_month  <= t.month;
    in_set_day    <= t.day;
    in_set_hour   <= t.hour;
    in_set_minute <= t.minute;
    in_set_second <= t.second;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_set(input time_t t);
    send_word(OP_SET, t);
  endtask

  // set fields carry junk on ticks
  task automatic send_ticks(input int n);
    repeat (n) send_word(OP_TICK, any_time());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  initial begin
    int kind;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_ticks(1);
    send_set(stamp(0, 0, 0, 0, 0, 0));
    send_ticks(1);
    send_set(stamp(4095, 15, 31, 31, 63, 63));
    send_ticks(1);
    send_set(stamp(4095, 12, 31, 23, 59, 59));
    send_ticks(1);
    send_set(stamp(1999, 12, 31, 23, 59, 59));
    send_ticks(1);
    send_set(stamp(2000, 2, 29, 23, 59, 59));
    send_ticks(1);
    send_set(stamp(1900, 2, 28, 23, 59, 59));
    send_ticks(1);
    send_set(stamp(2023, 2, 29, 0, 0, 0));
    send_set(stamp(2100, 2, 29, 12, 0, 0));
    send_set(stamp(2010, 0, 31, 23, 59, 59));
    send_ticks(1);
    send_set(stamp(2021, 4, 31, 23, 59, 59));
    send_ticks(1);
    send_set(stamp(2021, 5, 2, 0, 0, 0));
    send_set(stamp(2017, 6, 15, 1, 59, 59));
    send_ticks(1);
    send_set(stamp(2024, 10, 20, 13, 9, 59));
    send_ticks(1);
    send_set(stamp(2030, 7, 4, 24, 60, 60));
    send_ticks(1);
    drain();

    while (words_sent < RANDOM_WORDS + 30) begin
      kind = $urandom_range(0, 15);
      send_burst = $urandom_range(0, 5) == 0;
      if (kind <= 8) begin
        send_set(near_rollover());
        send_ticks($urandom_range(1, 16));
      end else if (kind <= 11) begin
        send_set(valid_time());
        send_ticks($urandom_range(0, 6));
      end else if (kind <= 13) begin
        send_set(any_time());
        send_ticks($urandom_range(0, 4));
      end else if (kind == 14) begin
        send_ticks($urandom_range(1, 20));
      end else begin
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d tick and %0d set words; %0d results held a valid time,",
             shadow.tick_words, shadow.set_words, shadow.valid_readings);
    $display("%0d crossed midnight, with random gaps and output stalls.", shadow.midnights);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("rtc_calendar_counter test passed");
    end else begin
      $display("rtc_calendar_counter test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/rcc_pkg.sv
sv/rcc_update.sv
sv/rcc_days.sv
sv/rcc_secs.sv
sv/rtc_calendar_counter.sv
bench/testbench.sv
